/* rtl/core/spsp_pkg.sv */
// Shared types and constants for the sensor pair stream parser.
// Used by the front classifier, the word queue, the back executor and the top level.
package spsp_pkg;

  localparam int unsigned TIMER_WIDTH_DEF = 16;
  localparam int unsigned QUEUE_DEPTH     = 2;
  localparam int unsigned TIMEOUT_W       = 16;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd2000;

  // Input word kinds
  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_TICK  = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;
  localparam logic [1:0] KIND_PIN   = 2'd3;

  // Configuration register indexes
  localparam logic CFG_TIMEOUT   = 1'b0;
  localparam logic CFG_ACT_LOW   = 1'b1;

  // Stream bytes
  localparam logic [7:0] HDR_BYTE     = 8'd19;
  localparam logic [7:0] LEN_BYTE     = 8'd14;
  localparam logic [7:0] ID_BUMP      = 8'd7;
  localparam logic [7:0] ID_WALL      = 8'd8;
  localparam logic [7:0] ID_CLIFF_L   = 8'd9;
  localparam logic [7:0] ID_CLIFF_FL  = 8'd10;
  localparam logic [7:0] ID_CLIFF_FR  = 8'd11;
  localparam logic [7:0] ID_CLIFF_R   = 8'd12;
  localparam logic [7:0] ID_BUTTONS   = 8'd18;

  // Button bits and latch bits
  localparam logic [7:0] BTN_PLAY = 8'h01;
  localparam logic [7:0] BTN_ADV  = 8'h04;
  localparam logic [2:0] LATCH_PLAY  = 3'h1;
  localparam logic [2:0] LATCH_ADV   = 3'h2;
  localparam logic [2:0] LATCH_BUMP  = 3'h4;

  typedef enum logic [2:0] {
    PH_ID    = 3'b001,
    PH_VALUE = 3'b010,
    PH_SKIP  = 3'b100
  } phase_e;

  typedef enum logic [2:0] {
    OP_IDLE,
    OP_VALUE,
    OP_TICK,
    OP_CLEAR,
    OP_PIN
  } op_e;

  typedef enum logic [2:0] {
    TGT_BUMP,
    TGT_WALL,
    TGT_CLIFF_L,
    TGT_CLIFF_FL,
    TGT_CLIFF_FR,
    TGT_CLIFF_R,
    TGT_BUTTONS
  } tgt_e;

  typedef struct packed {
    op_e        op;
    tgt_e       tgt;
    logic [7:0] data;
    logic       pin;
    logic [2:0] mask;
  } op_t;

endpackage

/* rtl/core/spsp_front.sv */
// Front classifier: tracks the ID/value pairing of the byte stream and turns
// each input word into an operation for the back. Depends on spsp_pkg.
module spsp_front
  import spsp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       take_i,
  input  logic [1:0] kind_i,
  input  logic [7:0] data_byte_i,
  input  logic       pin_level_i,
  input  logic [2:0] clear_mask_i,
  output op_t        op_o
);

  phase_e phase_q, phase_d;
  tgt_e   tgt_q, tgt_d;
  op_e    op;

  always_comb begin
    phase_d = phase_q;
    tgt_d   = tgt_q;
    op      = OP_IDLE;
    case (kind_i)
      KIND_BYTE: begin
        unique case (phase_q)
          PH_VALUE: begin
            op      = OP_VALUE;
            phase_d = PH_ID;
          end
          PH_SKIP: phase_d = PH_ID;
          default: begin
            phase_d = PH_ID;
            unique case (data_byte_i)
              HDR_BYTE: phase_d = PH_SKIP;
              LEN_BYTE: phase_d = PH_ID;
              ID_BUMP: begin
                phase_d = PH_VALUE;
                tgt_d   = TGT_BUMP;
              end
              ID_WALL: begin
                phase_d = PH_VALUE;
                tgt_d   = TGT_WALL;
              end
              ID_CLIFF_L: begin
                phase_d = PH_VALUE;
                tgt_d   = TGT_CLIFF_L;
              end
              ID_CLIFF_FL: begin
                phase_d = PH_VALUE;
                tgt_d   = TGT_CLIFF_FL;
              end
              ID_CLIFF_FR: begin
                phase_d = PH_VALUE;
                tgt_d   = TGT_CLIFF_FR;
              end
              ID_CLIFF_R: begin
                phase_d = PH_VALUE;
                tgt_d   = TGT_CLIFF_R;
              end
              ID_BUTTONS: begin
                phase_d = PH_VALUE;
                tgt_d   = TGT_BUTTONS;
              end
              default: phase_d = PH_ID;
            endcase
          end
        endcase
      end
      KIND_TICK:  op = OP_TICK;
      KIND_CLEAR: op = OP_CLEAR;
      KIND_PIN:   op = OP_PIN;
      default:    op = OP_IDLE;
    endcase
  end

  always_comb begin
    op_o.op   = op;
    op_o.tgt  = tgt_q;
    op_o.data = data_byte_i;
    op_o.pin  = pin_level_i;
    op_o.mask = clear_mask_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_ID;
      tgt_q   <= TGT_BUMP;
    end else if (take_i) begin
      phase_q <= phase_d;
      tgt_q   <= tgt_d;
    end
  end

endmodule

/* rtl/core/spsp_queue.sv */
// Short queue of classified operations between front and back.
// Depends on spsp_pkg for the operation type and depth.
module spsp_queue
  import spsp_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  op_t  push_op_i,
  output logic full_o,
  input  logic pop_i,
  output logic avail_o,
  output op_t  pop_op_o
);

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(QUEUE_DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(QUEUE_DEPTH);

  op_t            entry_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o   = (count_q == CntFull);
  assign avail_o  = (count_q != '0);
  assign pop_op_o = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

/* rtl/core/spsp_back.sv */
// Back executor: holds the cached sensor state, latches, link timer and the
// configuration registers, and drives the result register. Depends on spsp_pkg.
module spsp_back
  import spsp_pkg::*;
#(
  parameter int unsigned TIMER_WIDTH = TIMER_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_idx_i,
  input  logic [TIMEOUT_W-1:0] cfg_data_i,
  input  logic                 avail_i,
  input  op_t                  op_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 bump_left_o,
  output logic                 bump_right_o,
  output logic [3:0]           cliff_flags_o,
  output logic                 wall_seen_o,
  output logic [7:0]           button_bits_o,
  output logic                 play_edge_o,
  output logic                 advance_edge_o,
  output logic                 bumper_event_o,
  output logic                 link_up_o,
  output logic                 value_taken_o
);

  localparam int unsigned CmpW = (TIMER_WIDTH > TIMEOUT_W) ? TIMER_WIDTH : TIMEOUT_W;

  logic [TIMEOUT_W-1:0]   timeout_q;
  logic                   act_low_q;
  logic [1:0]             bump_q, bump_d;
  logic [3:0]             cliff_q, cliff_d;
  logic                   wall_q, wall_d;
  logic [7:0]             btn_q, btn_d;
  logic [2:0]             latch_q, latch_d, shown;
  logic [TIMER_WIDTH-1:0] ms_q, ms_d;
  logic                   seen_q, seen_d;
  logic                   taken, link;
  logic                   nz;
  logic                   out_valid_q;

  // Take the next word when the result register is empty or being drained
  assign pop_o       = avail_i && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;
  assign nz          = (op_i.data != 8'd0);

  always_comb begin
    bump_d  = bump_q;
    cliff_d = cliff_q;
    wall_d  = wall_q;
    btn_d   = btn_q;
    latch_d = latch_q;
    ms_d    = ms_q;
    seen_d  = seen_q;
    taken   = 1'b0;
    case (op_i.op)
      OP_VALUE: begin
        taken  = 1'b1;
        ms_d   = '0;
        seen_d = 1'b1;
        case (op_i.tgt)
          TGT_BUMP:     bump_d     = op_i.data[1:0];
          TGT_WALL:     wall_d     = nz;
          TGT_CLIFF_L:  cliff_d[0] = nz;
          TGT_CLIFF_FL: cliff_d[1] = nz;
          TGT_CLIFF_FR: cliff_d[2] = nz;
          TGT_CLIFF_R:  cliff_d[3] = nz;
          TGT_BUTTONS: begin
            if (((btn_q & BTN_PLAY) == 8'd0) && ((op_i.data & BTN_PLAY) != 8'd0)) begin
              latch_d = latch_d | LATCH_PLAY;
            end
            if (((btn_q & BTN_ADV) == 8'd0) && ((op_i.data & BTN_ADV) != 8'd0)) begin
              latch_d = latch_d | LATCH_ADV;
            end
            btn_d = op_i.data;
          end
          default: ;
        endcase
      end
      OP_TICK: begin
        if (ms_q != '1) begin
          ms_d = ms_q + 1'b1;
        end
      end
      OP_PIN: begin
        if (op_i.pin == !act_low_q) begin
          latch_d = latch_q | LATCH_BUMP;
        end
      end
      default: ;
    endcase
    // Report the latches before a clear drops them
    shown = latch_d;
    if (op_i.op == OP_CLEAR) begin
      latch_d = latch_d & ~op_i.mask;
    end
    link = seen_d && (CmpW'(ms_d) < CmpW'(timeout_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TIMEOUT_RESET;
      act_low_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_TIMEOUT: timeout_q <= cfg_data_i;
        CFG_ACT_LOW: act_low_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bump_q      <= '0;
      cliff_q     <= '0;
      wall_q      <= 1'b0;
      btn_q       <= '0;
      latch_q     <= '0;
      ms_q        <= '0;
      seen_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        bump_q  <= bump_d;
        cliff_q <= cliff_d;
        wall_q  <= wall_d;
        btn_q   <= btn_d;
        latch_q <= latch_d;
        ms_q    <= ms_d;
        seen_q  <= seen_d;
      end
      if (pop_o) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      bump_left_o    <= bump_d[1];
      bump_right_o   <= bump_d[0];
      cliff_flags_o  <= cliff_d;
      wall_seen_o    <= wall_d;
      button_bits_o  <= btn_d;
      play_edge_o    <= shown[0];
      advance_edge_o <= shown[1];
      bumper_event_o <= shown[2];
      link_up_o      <= link;
      value_taken_o  <= taken;
    end
  end

endmodule

/* rtl/core/sensor_pair_stream_parser.sv */
// Sensor pair stream parser, top level: front classifier, operation queue, back executor.
// Depends on spsp_pkg, spsp_front, spsp_queue and spsp_back.
//
// Input channel (in_valid_i / in_stall_o): one word per stream byte, millisecond
// tick, latch clear or bumper pin change, selected by kind_i.
// Output channel (out_valid_o / out_stall_i): exactly one result word per input
// word, in order, with the cached sensor state, the edge latches and link status.
// Configuration: cfg_we_i writes the register picked by cfg_idx_i (0 timeout in ms,
// 1 bumper active low) from cfg_data_i; write only while idle.
// Path: an accepted input word is written into the queue; the back then loads it into the
// result register when that register is empty or being drained.
// Throughput: one word per cycle sustained while the receiver does not stall; the back
// retires one queue entry per cycle into the result register when it is not stalled.
// Receiver stall: the result register holds, the two-entry queue fills, and then
// in_stall_o rises until the receiver drains a result.
// Reset: asynchronous, active low; clears the parser, cached state, latches, timer,
// queue and result valid, and loads timeout 2000 ms and bumper active low.
module sensor_pair_stream_parser
  import spsp_pkg::*;
#(
  parameter int unsigned TIMER_WIDTH = TIMER_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_idx_i,
  input  logic [TIMEOUT_W-1:0] cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           kind_i,
  input  logic [7:0]           data_byte_i,
  input  logic                 pin_level_i,
  input  logic [2:0]           clear_mask_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 bump_left_o,
  output logic                 bump_right_o,
  output logic [3:0]           cliff_flags_o,
  output logic                 wall_seen_o,
  output logic [7:0]           button_bits_o,
  output logic                 play_edge_o,
  output logic                 advance_edge_o,
  output logic                 bumper_event_o,
  output logic                 link_up_o,
  output logic                 value_taken_o
);

  logic take, full, avail, pop;
  op_t  push_op, pop_op;

  assign in_stall_o = full;
  assign take       = in_valid_i && !full;

  spsp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .take_i       (take),
    .kind_i       (kind_i),
    .data_byte_i  (data_byte_i),
    .pin_level_i  (pin_level_i),
    .clear_mask_i (clear_mask_i),
    .op_o         (push_op)
  );

  spsp_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (take),
    .push_op_i (push_op),
    .full_o    (full),
    .pop_i     (pop),
    .avail_o   (avail),
    .pop_op_o  (pop_op)
  );

  spsp_back #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .avail_i        (avail),
    .op_i           (pop_op),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .bump_left_o    (bump_left_o),
    .bump_right_o   (bump_right_o),
    .cliff_flags_o  (cliff_flags_o),
    .wall_seen_o    (wall_seen_o),
    .button_bits_o  (button_bits_o),
    .play_edge_o    (play_edge_o),
    .advance_edge_o (advance_edge_o),
    .bumper_event_o (bumper_event_o),
    .link_up_o      (link_up_o),
    .value_taken_o  (value_taken_o)
  );

endmodule

/* tb/sensor_pair_stream_parser_tb.sv */
// Self-checking bench for sensor_pair_stream_parser: directed words, then random
// ID/value traffic, ticks, clears and pin changes under several stall patterns.
// Depends on spsp_pkg and the sensor_pair_stream_parser RTL.
module sensor_pair_stream_parser_tb;
  import spsp_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PHASE_WORDS = 280;

  typedef struct packed {
    logic       bump_l;
    logic       bump_r;
    logic [3:0] cliff;
    logic       wall;
    logic [7:0] buttons;
    logic       play;
    logic       adv;
    logic       bumper;
    logic       link;
    logic       taken;
  } sensor_word_t;

  class parse_scoreboard;
    logic [TIMEOUT_W-1:0]       timeout;
    logic                       act_low;
    phase_e                     parse_st;
    logic [7:0]                 armed_id;
    logic [1:0]                 bump_bits;
    logic [3:0]                 cliff_bits;
    logic                       wall_bit;
    logic [7:0]                 buttons_last;
    logic [2:0]                 latches;
    logic [TIMER_WIDTH_DEF-1:0] ms_idle;
    logic                       value_seen;
    sensor_word_t               sensor_due[$];
    int unsigned                fails;
    int unsigned                checked;

    function new();
      timeout      = TIMEOUT_RESET;
      act_low      = 1'b1;
      parse_st     = PH_ID;
      armed_id     = '0;
      bump_bits    = '0;
      cliff_bits   = '0;
      wall_bit     = 1'b0;
      buttons_last = '0;
      latches      = '0;
      ms_idle      = '0;
      value_seen   = 1'b0;
      fails        = 0;
      checked      = 0;
    endfunction

    task report(string what);
      $display("error: %s", what);
      fails++;
    endtask

    function int unsigned pending();
      return sensor_due.size();
    endfunction

    // Update the cached sensor state from the value that completes a pair.
    function void apply_value(logic [7:0] v);
      case (armed_id)
        ID_BUMP:     bump_bits = v[1:0];
        ID_WALL:     wall_bit = |v;
        ID_CLIFF_L:  cliff_bits[0] = |v;
        ID_CLIFF_FL: cliff_bits[1] = |v;
        ID_CLIFF_FR: cliff_bits[2] = |v;
        ID_CLIFF_R:  cliff_bits[3] = |v;
        ID_BUTTONS: begin
          if ((buttons_last & BTN_PLAY) == 0 && (v & BTN_PLAY) != 0) latches |= LATCH_PLAY;
          if ((buttons_last & BTN_ADV) == 0 && (v & BTN_ADV) != 0) latches |= LATCH_ADV;
          buttons_last = v;
        end
        default: ;
      endcase
      ms_idle    = '0;
      value_seen = 1'b1;
      parse_st   = PH_ID;
      armed_id   = '0;
    endfunction

    function void note_word(logic [1:0] kind, logic [7:0] b, logic pin, logic [2:0] mask);
      sensor_word_t w;
      logic         taken;
      logic [2:0]   shown;
      taken = 1'b0;
      case (kind)
        KIND_BYTE: begin
          if (parse_st == PH_VALUE) begin
            apply_value(b);
            taken = 1'b1;
          end else if (parse_st == PH_SKIP) begin
            parse_st = PH_ID;
          end else if (b == HDR_BYTE) begin
            parse_st = PH_SKIP;
          end else if ((b >= ID_BUMP && b <= ID_CLIFF_R) || b == ID_BUTTONS) begin
            armed_id = b;
            parse_st = PH_VALUE;
          end else begin
            parse_st = PH_ID;
          end
        end
        KIND_TICK: if (ms_idle != {TIMER_WIDTH_DEF{1'b1}}) ms_idle++;
        KIND_PIN:  if (pin == !act_low) latches |= LATCH_BUMP;
        default: ;
      endcase
      shown = latches;
      if (kind == KIND_CLEAR) latches &= ~mask;
      w.bump_l  = bump_bits[1];
      w.bump_r  = bump_bits[0];
      w.cliff   = cliff_bits;
      w.wall    = wall_bit;
      w.buttons = buttons_last;
      w.play    = shown[0];
      w.adv     = shown[1];
      w.bumper  = shown[2];
      w.link    = value_seen && (ms_idle < TIMER_WIDTH_DEF'(timeout));
      w.taken   = taken;
      sensor_due.push_back(w);
    endfunction

    task field(string nm, logic [7:0] g, logic [7:0] w);
      if (g !== w) report($sformatf("result %0d %s got %0h want %0h", checked, nm, g, w));
    endtask

    task check_word(sensor_word_t got);
      sensor_word_t want;
      if (sensor_due.size() == 0) begin
        report($sformatf("result with nothing due: %p", got));
        return;
      end
      want = sensor_due.pop_front();
      field("bump_left", 8'(got.bump_l), 8'(want.bump_l));
      field("bump_right", 8'(got.bump_r), 8'(want.bump_r));
      field("cliff_flags", 8'(got.cliff), 8'(want.cliff));
      field("wall_seen", 8'(got.wall), 8'(want.wall));
      field("button_bits", got.buttons, want.buttons);
      field("play_edge", 8'(got.play), 8'(want.play));
      field("advance_edge", 8'(got.adv), 8'(want.adv));
      field("bumper_event", 8'(got.bumper), 8'(want.bumper));
      field("link_up", 8'(got.link), 8'(want.link));
      field("value_taken", 8'(got.taken), 8'(want.taken));
      checked++;
    endtask
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic                 cfg_idx_i = CFG_TIMEOUT;
  logic [TIMEOUT_W-1:0] cfg_data_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic [1:0]           kind_i = KIND_BYTE;
  logic [7:0]           data_byte_i = '0;
  logic                 pin_level_i = 1'b0;
  logic [2:0]           clear_mask_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic                 bump_left_o;
  logic                 bump_right_o;
  logic [3:0]           cliff_flags_o;
  logic                 wall_seen_o;
  logic [7:0]           button_bits_o;
  logic                 play_edge_o;
  logic                 advance_edge_o;
  logic                 bumper_event_o;
  logic                 link_up_o;
  logic                 value_taken_o;

  parse_scoreboard sb;
  int unsigned     gap_pct = 0;
  int unsigned     stall_pct = 0;
  int unsigned     words_sent = 0;
  int unsigned     cycle_count = 0;

  sensor_pair_stream_parser u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .kind_i         (kind_i),
    .data_byte_i    (data_byte_i),
    .pin_level_i    (pin_level_i),
    .clear_mask_i   (clear_mask_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .bump_left_o    (bump_left_o),
    .bump_right_o   (bump_right_o),
    .cliff_flags_o  (cliff_flags_o),
    .wall_seen_o    (wall_seen_o),
    .button_bits_o  (button_bits_o),
    .play_edge_o    (play_edge_o),
    .advance_edge_o (advance_edge_o),
    .bumper_event_o (bumper_event_o),
    .link_up_o      (link_up_o),
    .value_taken_o  (value_taken_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic bit chance(int unsigned pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  always @(posedge clk_i) begin
    out_stall_i <= chance(stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o)
      sb.note_word(kind_i, data_byte_i, pin_level_i, clear_mask_i);
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_word({bump_left_o, bump_right_o, cliff_flags_o, wall_seen_o, button_bits_o,
                     play_edge_o, advance_edge_o, bumper_event_o, link_up_o, value_taken_o});
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("sensor_pair_stream_parser: mismatch");
      $finish;
    end
  end

  // Present one word and hold it until accepted; valid stays high for the next call.
  task automatic push_word(input logic [1:0] k, input logic [7:0] b, input logic p,
                           input logic [2:0] m);
    while (chance(gap_pct)) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    kind_i       <= k;
    data_byte_i  <= b;
    pin_level_i  <= p;
    clear_mask_i <= m;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    words_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    push_word(KIND_BYTE, b, 1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)));
  endtask

  task automatic send_tick();
    push_word(KIND_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
              3'($urandom_range(0, 7)));
  endtask

  task automatic send_clear(input logic [2:0] m);
    push_word(KIND_CLEAR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), m);
  endtask

  task automatic send_pin(input logic p);
    push_word(KIND_PIN, 8'($urandom_range(0, 255)), p, 3'($urandom_range(0, 7)));
  endtask

  // Drop valid and hold off until every due result has arrived.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic idx, input logic [TIMEOUT_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    if (idx == CFG_TIMEOUT) sb.timeout = val;
    else sb.act_low = val[0];
  endtask

  function automatic logic [7:0] id_pick();
    case ($urandom_range(0, 6))
      0:       return ID_BUMP;
      1:       return ID_WALL;
      2:       return ID_CLIFF_L;
      3:       return ID_CLIFF_FL;
      4:       return ID_CLIFF_FR;
      5:       return ID_CLIFF_R;
      default: return ID_BUTTONS;
    endcase
  endfunction

  function automatic logic [7:0] value_pick();
    case ($urandom_range(0, 9))
      0:       return HDR_BYTE;
      1:       return LEN_BYTE;
      2:       return 8'h00;
      3:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic random_chunk();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      send_byte(id_pick());
      send_byte(value_pick());
    end else if (pick < 55) begin
      send_byte(HDR_BYTE);
      send_byte(chance(50) ? id_pick() : 8'($urandom_range(0, 255)));
    end else if (pick < 70) begin
      repeat ($urandom_range(1, 12)) send_tick();
    end else if (pick < 78) begin
      send_clear(3'($urandom_range(0, 7)));
    end else if (pick < 86) begin
      send_pin(1'($urandom_range(0, 1)));
    end else if (pick < 96) begin
      send_byte(chance(20) ? LEN_BYTE : 8'($urandom_range(0, 255)));
    end else begin
      // non-byte words between an ID and its value leave the parser armed
      send_byte(id_pick());
      send_tick();
      send_pin(1'($urandom_range(0, 1)));
      send_clear(3'($urandom_range(0, 7)));
      send_byte(value_pick());
    end
  endtask

  initial begin
    logic [TIMEOUT_W-1:0] tmo;
    int unsigned          goal;
    sb = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset config, no idling
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(LEN_BYTE);
    send_byte(HDR_BYTE);
    send_byte(ID_BUMP);
    send_byte(HDR_BYTE);
    send_byte(HDR_BYTE);
    send_byte(ID_BUMP);
    send_byte(HDR_BYTE);
    send_byte(ID_WALL);
    send_byte(LEN_BYTE);
    send_tick();
    send_byte(ID_CLIFF_L);
    send_byte(8'hFF);
    send_byte(ID_CLIFF_FL);
    send_byte(8'h01);
    send_byte(ID_CLIFF_FR);
    send_byte(8'h80);
    send_byte(ID_CLIFF_R);
    send_byte(8'h00);
    send_byte(ID_BUTTONS);
    send_byte(8'h05);
    send_pin(1'b0);
    send_pin(1'b1);
    send_clear(3'b111);
    send_clear(3'b000);
    send_byte(ID_BUTTONS);
    send_byte(8'hFA);

    for (int p = 0; p < 6; p++) begin
      drain();
      case (p)
        0:       tmo = 16'd5;
        1:       tmo = 16'd0;
        2:       tmo = 16'hFFFF;
        3:       tmo = 16'd1;
        default: tmo = 16'($urandom_range(2, 12));
      endcase
      write_cfg(CFG_TIMEOUT, tmo);
      write_cfg(CFG_ACT_LOW, {15'($urandom_range(0, 32767)), 1'(p % 2)});
      case (p % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 61; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 61; end
        default: begin gap_pct = 10; stall_pct = 10; end
      endcase
      goal = words_sent + PHASE_WORDS;
      while (words_sent < goal) begin
        random_chunk();
        if (words_sent >= goal - PHASE_WORDS / 2 && words_sent < goal - PHASE_WORDS / 2 + 2)
          drain();
      end
    end

    drain();
    repeat (8) @(posedge clk_i);
    if (sb.fails == 0) begin
      $display("sensor_pair_stream_parser: match");
    end else begin
      $display("sensor_pair_stream_parser: mismatch");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/spsp_pkg.sv
rtl/core/spsp_front.sv
rtl/core/spsp_queue.sv
rtl/core/spsp_back.sv
rtl/core/sensor_pair_stream_parser.sv
tb/sensor_pair_stream_parser_tb.sv
